// ----- sv/twa_pkg.sv -----
`default_nettype none

package twa_pkg;

    // Widest operand type that the datapath carries.
    localparam int unsigned MAX_WIDTH  = 64;
    localparam int unsigned DATA_W     = 64;
    localparam int unsigned DIV_STAGES = 64;

    // Configuration register indexes.
    localparam logic [0:0] REG_WIDTH_CODE = 1'b0;
    localparam logic [0:0] REG_IS_SIGNED  = 1'b1;

    // Operation codes.
    typedef enum logic [3:0] {
        OP_SET = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_MUL = 4'd3,
        OP_DIV = 4'd4,
        OP_NOT = 4'd5,
        OP_AND = 4'd6,
        OP_OR  = 4'd7,
        OP_XOR = 4'd8,
        OP_SHL = 4'd9,
        OP_SHR = 4'd10
    } op_t;

    // Side information that rides along with the divider pipeline.
    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              is_div;
        logic              dz;
        logic              neg_q;
    } pipe_info_t;

    // Effective operand width for a width code, limited to MAX_WIDTH.
    function automatic logic [6:0] eff_width(input logic [1:0] wc);
        logic [7:0] w;
        w = 8'd8 << wc;
        if (w > 8'(MAX_WIDTH))
        begin
            w = 8'(MAX_WIDTH);
        end
        return w[6:0];
    endfunction

    // Reduce a value to the type: mask, then sign-extend when signed.
    function automatic logic [DATA_W-1:0] wrap(input logic [DATA_W-1:0] x,
                                               input logic [1:0] wc,
                                               input logic sgn);
        logic [6:0]        w;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] y;
        w = eff_width(wc);
        if (w >= 7'd64)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << w[5:0]) - 64'd1;
        end
        y = x & m;
        if (sgn && y[6'(w - 7'd1)])
        begin
            y = y | ~m;
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- sv/twa_div_pipe.sv -----
`default_nettype none

module twa_div_pipe (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [63:0]               dividend,
    input  wire logic [63:0]               divisor,
    input  wire twa_pkg::pipe_info_t       in_info,
    output logic                           out_valid,
    output logic [63:0]                    quotient,
    output twa_pkg::pipe_info_t            out_info
);
    import twa_pkg::*;

    // Stage arrays; entry 0 is the input side, entry DIV_STAGES the last register.
    logic [DIV_STAGES:0] valid_reg;
    logic [DATA_W-1:0]   rem_reg [DIV_STAGES+1];
    logic [DATA_W-1:0]   dvd_reg [DIV_STAGES+1];
    logic [DATA_W-1:0]   dsr_reg [DIV_STAGES+1];
    pipe_info_t          info_reg [DIV_STAGES+1];

    assign valid_reg[0] = in_valid;
    assign rem_reg[0]   = '0;
    assign dvd_reg[0]   = dividend;
    assign dsr_reg[0]   = divisor;
    assign info_reg[0]  = in_info;

    // One restoring quotient bit per stage; the quotient replaces the dividend.
    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic [DATA_W:0]   trial;
        logic              fits;
        logic [DATA_W-1:0] rem_next;
        logic [DATA_W-1:0] dvd_next;

        always_comb
        begin
            trial    = {rem_reg[g], dvd_reg[g][DATA_W-1]};
            fits     = trial >= {1'b0, dsr_reg[g]};
            rem_next = fits ? DATA_W'(trial - {1'b0, dsr_reg[g]}) : trial[DATA_W-1:0];
            dvd_next = {dvd_reg[g][DATA_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g+1] <= 1'b0;
            end
            else
            begin
                valid_reg[g+1] <= valid_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g+1]  <= rem_next;
            dvd_reg[g+1]  <= dvd_next;
            dsr_reg[g+1]  <= dsr_reg[g];
            info_reg[g+1] <= info_reg[g];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES];
    assign quotient  = dvd_reg[DIV_STAGES];
    assign out_info  = info_reg[DIV_STAGES];

endmodule

`default_nettype wire

// ----- sv/width_typed_wrapping_alu.sv -----
// Every operation takes the same path from an accepted start to the done strobe: stage 1 to the output register.
// Throughput: one transaction per cycle; busy is always low.
// The 64-stage divider pipeline, one quotient bit per stage, sets the latency.
// The receiver cannot stall; done marks each result for exactly one cycle.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the
// configuration defaults: 64-bit width, unsigned.
`default_nettype none

module width_typed_wrapping_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [0:0]        wr_index,
    input  wire logic [1:0]        wr_data,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [3:0]        req_type,
    input  wire logic [63:0]       left_value,
    input  wire logic [63:0]       right_value,
    input  wire logic signed [7:0] shift_amount,
    output logic                   done,
    output logic [63:0]            result_value,
    output logic                   div_by_zero
);
    import twa_pkg::*;

    localparam int unsigned LATENCY = 3 + DIV_STAGES + 1;

    // Configuration registers.
    logic [1:0] width_code_reg;
    logic       is_signed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_code_reg <= 2'd3;
            is_signed_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WIDTH_CODE: width_code_reg <= wr_data;
                REG_IS_SIGNED:  is_signed_reg  <= wr_data[0];
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: capture the transaction with operands reduced to the type.
    logic              s1_valid_reg;
    logic [3:0]        s1_op_reg;
    logic [DATA_W-1:0] s1_l_reg;
    logic [DATA_W-1:0] s1_r_reg;
    logic [7:0]        s1_sa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg <= req_type;
        s1_l_reg  <= wrap(left_value, width_code_reg, is_signed_reg);
        s1_r_reg  <= wrap(right_value, width_code_reg, is_signed_reg);
        s1_sa_reg <= shift_amount;
    end

    // Stage 2: simple operations, shifts, multiplier partial products, divide setup.
    logic [6:0]        s2_w;
    logic              s2_sneg;
    logic [7:0]        s2_dist;
    logic              s2_go_left;
    logic              s2_lneg;
    logic              s2_rneg;
    logic [DATA_W-1:0] s2_shl;
    logic [DATA_W-1:0] s2_shr;
    logic [DATA_W-1:0] s2_res_next;

    always_comb
    begin
        s2_w       = eff_width(width_code_reg);
        s2_sneg    = s1_sa_reg[7];
        s2_dist    = s2_sneg ? 8'(-s1_sa_reg) : s1_sa_reg;
        s2_go_left = (s1_op_reg == OP_SHL) ^ s2_sneg;
        s2_lneg    = is_signed_reg && s1_l_reg[DATA_W-1];
        s2_rneg    = is_signed_reg && s1_r_reg[DATA_W-1];

        if (s2_dist >= {1'b0, s2_w})
        begin
            s2_shl = '0;
            s2_shr = s2_lneg ? wrap('1, width_code_reg, is_signed_reg) : '0;
        end
        else
        begin
            s2_shl = wrap(s1_l_reg << s2_dist[5:0], width_code_reg, is_signed_reg);
            s2_shr = wrap(s2_lneg ? ~((~s1_l_reg) >> s2_dist[5:0])
                                  : s1_l_reg >> s2_dist[5:0],
                          width_code_reg, is_signed_reg);
        end

        case (s1_op_reg) inside
            OP_SET:  s2_res_next = s1_r_reg;
            OP_ADD:  s2_res_next = wrap(s1_l_reg + s1_r_reg, width_code_reg, is_signed_reg);
            OP_SUB:  s2_res_next = wrap(s1_l_reg - s1_r_reg, width_code_reg, is_signed_reg);
            OP_NOT:  s2_res_next = wrap(~s1_l_reg, width_code_reg, is_signed_reg);
            OP_AND:  s2_res_next = wrap(s1_l_reg & s1_r_reg, width_code_reg, is_signed_reg);
            OP_OR:   s2_res_next = wrap(s1_l_reg | s1_r_reg, width_code_reg, is_signed_reg);
            OP_XOR:  s2_res_next = wrap(s1_l_reg ^ s1_r_reg, width_code_reg, is_signed_reg);
            OP_SHL, OP_SHR: s2_res_next = s2_go_left ? s2_shl : s2_shr;
            default: s2_res_next = '0;
        endcase
    end

    logic              s2_valid_reg;
    logic [3:0]        s2_op_reg;
    logic [DATA_W-1:0] s2_res_reg;
    logic [63:0]       s2_pp_lo_reg;
    logic [31:0]       s2_pp_a_reg;
    logic [31:0]       s2_pp_b_reg;
    logic [DATA_W-1:0] s2_ml_reg;
    logic [DATA_W-1:0] s2_mr_reg;
    logic              s2_negq_reg;
    logic              s2_dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg    <= s1_op_reg;
        s2_res_reg   <= s2_res_next;
        s2_pp_lo_reg <= s1_l_reg[31:0] * s1_r_reg[31:0];
        s2_pp_a_reg  <= 32'(s1_l_reg[63:32] * s1_r_reg[31:0]);
        s2_pp_b_reg  <= 32'(s1_l_reg[31:0] * s1_r_reg[63:32]);
        s2_ml_reg    <= s2_lneg ? 64'(-s1_l_reg) : s1_l_reg;
        s2_mr_reg    <= s2_rneg ? 64'(-s1_r_reg) : s1_r_reg;
        s2_negq_reg  <= s2_lneg != s2_rneg;
        s2_dz_reg    <= s1_r_reg == '0;
    end

    // Stage 3: finish the product and pack the side information for the divider.
    logic [DATA_W-1:0] s3_prod;
    pipe_info_t        s3_info_next;

    always_comb
    begin
        s3_prod = s2_pp_lo_reg + {32'(s2_pp_a_reg + s2_pp_b_reg), 32'd0};
        s3_info_next.res    = (s2_op_reg == OP_MUL)
                              ? wrap(s3_prod, width_code_reg, is_signed_reg)
                              : s2_res_reg;
        s3_info_next.is_div = s2_op_reg == OP_DIV;
        s3_info_next.dz     = (s2_op_reg == OP_DIV) && s2_dz_reg;
        s3_info_next.neg_q  = s2_negq_reg;
    end

    logic              s3_valid_reg;
    pipe_info_t        s3_info_reg;
    logic [DATA_W-1:0] s3_ml_reg;
    logic [DATA_W-1:0] s3_mr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_info_reg <= s3_info_next;
        s3_ml_reg   <= s2_ml_reg;
        s3_mr_reg   <= s2_mr_reg;
    end

    // Divider pipeline; every transaction passes through it to keep order.
    logic        dv_valid;
    logic [63:0] dv_quot;
    pipe_info_t  dv_info;

    twa_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .dividend  (s3_ml_reg),
        .divisor   (s3_mr_reg),
        .in_info   (s3_info_reg),
        .out_valid (dv_valid),
        .quotient  (dv_quot),
        .out_info  (dv_info)
    );

    // Output stage: sign the quotient and select the final result.
    logic [DATA_W-1:0] out_res_next;

    always_comb
    begin
        if (!dv_info.is_div)
        begin
            out_res_next = dv_info.res;
        end
        else if (dv_info.dz)
        begin
            out_res_next = '0;
        end
        else
        begin
            out_res_next = wrap(dv_info.neg_q ? 64'(-dv_quot) : dv_quot,
                                width_code_reg, is_signed_reg);
        end
    end

    logic              done_reg;
    logic [DATA_W-1:0] result_reg;
    logic              dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
            dz_reg   <= dv_valid && dv_info.dz;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= out_res_next;
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign div_by_zero  = dz_reg;

`ifndef SYNTHESIS
    // Every accepted transaction produces a strobe after the fixed latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after fixed latency");

    // A divide-by-zero flag always comes with a zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_by_zero |-> (done && result_value == '0))
        else $error("divide by zero flagged with nonzero result");

    // A strobe only appears if a transaction entered the pipeline earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(dv_valid))
        else $error("result strobe without a pipeline transaction");
`endif

endmodule

`default_nettype wire
